FILE: rtl/strot_pkg.sv
// Shared types, register indexes and Voigt index tables for the stress tensor rotation unit.
`timescale 1ns / 1ps

package strot_pkg;

    localparam int STRESS_W      = 32;
    localparam int ROT_WIDTH_DEF = 20;
    localparam int ROT_FRAC_DEF  = 18;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_VOIGT     = 6;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ROT_ROW0 = 2'd0;
    localparam cfg_index_t CFG_ROT_ROW1 = 2'd1;
    localparam cfg_index_t CFG_ROT_ROW2 = 2'd2;

    localparam int unsigned VOIGT_I [NUM_VOIGT] = '{0, 1, 2, 0, 0, 1};
    localparam int unsigned VOIGT_J [NUM_VOIGT] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic signed [STRESS_W-1:0] stress_xx;
        logic signed [STRESS_W-1:0] stress_yy;
        logic signed [STRESS_W-1:0] stress_zz;
        logic signed [STRESS_W-1:0] stress_xy;
        logic signed [STRESS_W-1:0] stress_xz;
        logic signed [STRESS_W-1:0] stress_yz;
    } stress_in_t;

    typedef struct packed {
        logic signed [STRESS_W-1:0] rotated_xx;
        logic signed [STRESS_W-1:0] rotated_yy;
        logic signed [STRESS_W-1:0] rotated_zz;
        logic signed [STRESS_W-1:0] rotated_xy;
        logic signed [STRESS_W-1:0] rotated_xz;
        logic signed [STRESS_W-1:0] rotated_yz;
        logic                       saturated;
    } stress_out_t;

    typedef struct packed {
        logic valid;
    } pipe_ctrl_t;

endpackage

FILE: rtl/strot_sr_mult.sv
// Pipeline stages one and two: forms M = S * R from the Voigt column and the rotation.
`timescale 1ns / 1ps

module strot_sr_mult #(
    parameter int ROT_WIDTH = strot_pkg::ROT_WIDTH_DEF,
    parameter int ROT_FRAC  = strot_pkg::ROT_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  strot_pkg::pipe_ctrl_t                 in_ctrl,
    input  strot_pkg::stress_in_t                 stress,
    input  logic [2:0][3*ROT_WIDTH-1:0]           rot,
    output strot_pkg::pipe_ctrl_t                 out_ctrl,
    output logic signed [strot_pkg::STRESS_W+ROT_WIDTH-ROT_FRAC+1:0] m_out [3][3]
);

    localparam int SW = strot_pkg::STRESS_W;
    localparam int PW = SW + ROT_WIDTH;
    localparam int TW = PW - ROT_FRAC;
    localparam int MW = TW + 2;

    logic signed [SW-1:0]        s      [3][3];
    logic signed [ROT_WIDTH-1:0] r      [3][3];
    logic signed [PW-1:0]        p_full [3][3][3];
    logic signed [TW-1:0]        prod_next [3][3][3];
    logic signed [TW-1:0]        prod_reg  [3][3][3];
    logic                        valid1_reg;
    logic signed [MW-1:0]        m_next [3][3];
    logic signed [MW-1:0]        m_reg  [3][3];
    logic                        valid2_reg;

    always_comb
    begin
        s[0][0] = stress.stress_xx;
        s[1][1] = stress.stress_yy;
        s[2][2] = stress.stress_zz;
        s[0][1] = stress.stress_xy;
        s[1][0] = stress.stress_xy;
        s[0][2] = stress.stress_xz;
        s[2][0] = stress.stress_xz;
        s[1][2] = stress.stress_yz;
        s[2][1] = stress.stress_yz;
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                r[a][c] = rot[a][ROT_WIDTH*c +: ROT_WIDTH];
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    p_full[a][j][b]    = s[a][b] * r[b][j];
                    prod_next[a][j][b] = p_full[a][j][b][PW-1:ROT_FRAC];
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_next[a][j] = {{2{prod_reg[a][j][0][TW-1]}}, prod_reg[a][j][0]}
                             + {{2{prod_reg[a][j][1][TW-1]}}, prod_reg[a][j][1]}
                             + {{2{prod_reg[a][j][2][TW-1]}}, prod_reg[a][j][2]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_ctrl.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        m_reg    <= m_next;
    end

    assign out_ctrl.valid = valid2_reg;
    assign m_out          = m_reg;

endmodule

FILE: rtl/strot_rt_mult.sv
// Pipeline stages three and four: forms R^T * M, sums and saturates the six components.
`timescale 1ns / 1ps

module strot_rt_mult #(
    parameter int ROT_WIDTH = strot_pkg::ROT_WIDTH_DEF,
    parameter int ROT_FRAC  = strot_pkg::ROT_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  strot_pkg::pipe_ctrl_t                 in_ctrl,
    input  logic signed [strot_pkg::STRESS_W+ROT_WIDTH-ROT_FRAC+1:0] m_in [3][3],
    input  logic [2:0][3*ROT_WIDTH-1:0]           rot,
    output strot_pkg::pipe_ctrl_t                 out_ctrl,
    output strot_pkg::stress_out_t                result
);

    localparam int SW  = strot_pkg::STRESS_W;
    localparam int NV  = strot_pkg::NUM_VOIGT;
    localparam int MW  = SW + ROT_WIDTH - ROT_FRAC + 2;
    localparam int HW  = MW - ROT_FRAC;
    localparam int PHW = ROT_WIDTH + HW;
    localparam int PLW = ROT_WIDTH + ROT_FRAC + 1;
    localparam int LSW = PLW - ROT_FRAC;
    localparam int TTW = PHW + 1;
    localparam int OW  = TTW + 2;

    logic signed [ROT_WIDTH-1:0] r      [3][3];
    logic signed [HW-1:0]        mh     [3][3];
    logic signed [ROT_FRAC:0]    ml     [3][3];
    logic signed [PHW-1:0]       ph     [NV][3];
    logic signed [PLW-1:0]       pl     [NV][3];
    logic signed [LSW-1:0]       pl_sh  [NV][3];
    logic signed [TTW-1:0]       term_next [NV][3];
    logic signed [TTW-1:0]       term_reg  [NV][3];
    logic                        valid3_reg;
    logic signed [OW-1:0]        sum    [NV];
    logic [OW-SW:0]              sum_top [NV];
    logic [SW-1:0]               res_next [NV];
    logic [NV-1:0]               ovf;
    logic [SW-1:0]               res_reg  [NV];
    logic                        sat_reg;
    logic                        valid4_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                r[a][c]  = rot[a][ROT_WIDTH*c +: ROT_WIDTH];
                mh[a][c] = m_in[a][c][MW-1:ROT_FRAC];
                ml[a][c] = {1'b0, m_in[a][c][ROT_FRAC-1:0]};
            end
        end
        for (int k = 0; k < NV; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ph[k][a]    = r[a][strot_pkg::VOIGT_I[k]] * mh[a][strot_pkg::VOIGT_J[k]];
                pl[k][a]    = r[a][strot_pkg::VOIGT_I[k]] * ml[a][strot_pkg::VOIGT_J[k]];
                pl_sh[k][a] = pl[k][a][PLW-1:ROT_FRAC];
                term_next[k][a] = {ph[k][a][PHW-1], ph[k][a]}
                                + {{(TTW-LSW){pl_sh[k][a][LSW-1]}}, pl_sh[k][a]};
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NV; k++)
        begin
            sum[k] = {{2{term_reg[k][0][TTW-1]}}, term_reg[k][0]}
                   + {{2{term_reg[k][1][TTW-1]}}, term_reg[k][1]}
                   + {{2{term_reg[k][2][TTW-1]}}, term_reg[k][2]};
            sum_top[k] = sum[k][OW-1:SW-1];
            ovf[k]     = !((&sum_top[k]) || (~|sum_top[k]));
            if (ovf[k])
            begin
                res_next[k] = sum[k][OW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end
            else
            begin
                res_next[k] = sum[k][SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid3_reg <= in_ctrl.valid;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        res_reg  <= res_next;
        sat_reg  <= |ovf;
    end

    assign out_ctrl.valid    = valid4_reg;
    assign result.rotated_xx = res_reg[0];
    assign result.rotated_yy = res_reg[1];
    assign result.rotated_zz = res_reg[2];
    assign result.rotated_xy = res_reg[3];
    assign result.rotated_xz = res_reg[4];
    assign result.rotated_yz = res_reg[5];
    assign result.saturated  = sat_reg;

endmodule

FILE: rtl/stress_tensor_rotation_unit.sv
// Top level of the stress tensor rotation unit: rotation registers and the four-stage pipeline.
`timescale 1ns / 1ps

// Channel   Ports                                       Transfer
// command   start, busy, stress                         start high and busy low at a clock edge
// result    done, result                                done high, one cycle per result
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid and cfg_ready both high
//
// A new column can start in every cycle; busy stays low.
// Each result passes through the four register stages after its start transfer.
// Reset clears the pipeline valid bits and loads the identity rotation.
// The receiver cannot stall, so the pipeline never holds.

module stress_tensor_rotation_unit #(
    parameter int ROT_WIDTH = strot_pkg::ROT_WIDTH_DEF,
    parameter int ROT_FRAC  = strot_pkg::ROT_FRAC_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  strot_pkg::stress_in_t   stress,
    output logic                    done,
    output strot_pkg::stress_out_t  result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  strot_pkg::cfg_index_t   cfg_index,
    input  logic [3*ROT_WIDTH-1:0]  cfg_data
);

    localparam int MW = strot_pkg::STRESS_W + ROT_WIDTH - ROT_FRAC + 2;
    localparam int RRW = 3 * ROT_WIDTH;

    logic [2:0][RRW-1:0]   rot_reg;
    logic [2:0][RRW-1:0]   rot_next;
    strot_pkg::pipe_ctrl_t in_ctrl;
    strot_pkg::pipe_ctrl_t mid_ctrl;
    strot_pkg::pipe_ctrl_t out_ctrl;
    logic signed [MW-1:0]  m_mid [3][3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_ctrl.valid = start && !busy;

    always_comb
    begin
        rot_next = rot_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                strot_pkg::CFG_ROT_ROW0: rot_next[0] = cfg_data;
                strot_pkg::CFG_ROT_ROW1: rot_next[1] = cfg_data;
                strot_pkg::CFG_ROT_ROW2: rot_next[2] = cfg_data;
                default:                 rot_next    = rot_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rot_reg[k] <= {{(RRW-1){1'b0}}, 1'b1} << (ROT_FRAC + ROT_WIDTH * k);
            end
        end
        else
        begin
            rot_reg <= rot_next;
        end
    end

    strot_sr_mult #(
        .ROT_WIDTH (ROT_WIDTH),
        .ROT_FRAC  (ROT_FRAC)
    ) u_sr_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (in_ctrl),
        .stress   (stress),
        .rot      (rot_reg),
        .out_ctrl (mid_ctrl),
        .m_out    (m_mid)
    );

    strot_rt_mult #(
        .ROT_WIDTH (ROT_WIDTH),
        .ROT_FRAC  (ROT_FRAC)
    ) u_rt_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (mid_ctrl),
        .m_in     (m_mid),
        .rot      (rot_reg),
        .out_ctrl (out_ctrl),
        .result   (result)
    );

    assign done = out_ctrl.valid;

`ifndef ASSERT_OFF
    localparam logic [strot_pkg::STRESS_W-1:0] S_MAX = {1'b0, {(strot_pkg::STRESS_W-1){1'b1}}};
    localparam logic [strot_pkg::STRESS_W-1:0] S_MIN = {1'b1, {(strot_pkg::STRESS_W-1){1'b0}}};

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("Result strobe without a start transfer four cycles earlier.");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |->
            (result.rotated_xx == S_MAX || result.rotated_xx == S_MIN ||
             result.rotated_yy == S_MAX || result.rotated_yy == S_MIN ||
             result.rotated_zz == S_MAX || result.rotated_zz == S_MIN ||
             result.rotated_xy == S_MAX || result.rotated_xy == S_MIN ||
             result.rotated_xz == S_MAX || result.rotated_xz == S_MIN ||
             result.rotated_yz == S_MAX || result.rotated_yz == S_MIN))
        else $error("Saturation flag set with no component at a limit.");

    a_cfg_row_written: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == strot_pkg::CFG_ROT_ROW1) |=>
            (rot_reg[1] == $past(cfg_data) && $stable(rot_reg[0]) && $stable(rot_reg[2])))
        else $error("Configuration transfer did not update only the addressed row.");
`endif

endmodule

FILE: bench/stress_tensor_rotation_unit_test.sv
// Self-checking testbench for the stress tensor rotation unit with a bit-exact tensor predictor.
`timescale 1ns / 1ps

module stress_tensor_rotation_unit_test;

    localparam int ROT_W  = strot_pkg::ROT_WIDTH_DEF;
    localparam int ROT_FR = strot_pkg::ROT_FRAC_DEF;
    localparam int SW     = strot_pkg::STRESS_W;
    localparam int NV     = strot_pkg::NUM_VOIGT;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam strot_pkg::cfg_index_t CFG_UNUSED = 2'd3;

    localparam logic [ROT_W-1:0] ROT_ZERO    = 20'h00000;
    localparam logic [ROT_W-1:0] ROT_ONE     = 20'h40000;
    localparam logic [ROT_W-1:0] ROT_NEG_ONE = 20'hC0000;
    localparam logic [ROT_W-1:0] ROT_MAX     = 20'h7FFFF;
    localparam logic [ROT_W-1:0] ROT_MIN     = 20'h80000;

    localparam logic [SW-1:0] S_MAX  = 32'h7FFFFFFF;
    localparam logic [SW-1:0] S_MIN  = 32'h80000000;
    localparam logic [SW-1:0] S_ZERO = 32'h00000000;
    localparam logic [SW-1:0] S_NEG1 = 32'hFFFFFFFF;
    localparam logic [SW-1:0] S_UNIT = 32'h00010000;
    localparam logic [SW-1:0] S_ALT5 = 32'h55555555;
    localparam logic [SW-1:0] S_ALTA = 32'hAAAAAAAA;

    localparam longint STRESS_HI = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint STRESS_LO = -STRESS_HI - 1;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         start     = 1'b0;
    logic                         busy;
    strot_pkg::stress_in_t        stress    = '0;
    logic                         done;
    strot_pkg::stress_out_t       result;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    strot_pkg::cfg_index_t        cfg_index = strot_pkg::CFG_ROT_ROW0;
    logic [3*ROT_W-1:0]           cfg_data  = '0;

    logic [3*ROT_W-1:0]           rot_rows [3];
    strot_pkg::stress_in_t        pending_columns [$];
    strot_pkg::stress_out_t       expected_tensors [$];
    strot_pkg::stress_out_t       oldest_tensor;
    int                           mismatch_count = 0;
    int                           burst_left = 0;
    int                           gap_left = 0;
    int                           idle_cycles = 0;

    stress_tensor_rotation_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .stress    (stress),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic strot_pkg::stress_out_t rotate_tensor(strot_pkg::stress_in_t col);
        longint                  s [3][3];
        longint                  r [3][3];
        longint                  m [3][3];
        longint                  v [NV];
        logic signed [ROT_W-1:0] entry;
        strot_pkg::stress_out_t  res;
        s[0][0] = col.stress_xx;
        s[1][1] = col.stress_yy;
        s[2][2] = col.stress_zz;
        s[0][1] = col.stress_xy;
        s[1][0] = col.stress_xy;
        s[0][2] = col.stress_xz;
        s[2][0] = col.stress_xz;
        s[1][2] = col.stress_yz;
        s[2][1] = col.stress_yz;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                entry = rot_rows[a][ROT_W*b +: ROT_W];
                r[a][b] = entry;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m[a][j] = 0;
                for (int b = 0; b < 3; b++)
                    m[a][j] += (s[a][b] * r[b][j]) >>> ROT_FR;
            end
        end
        res.saturated = 1'b0;
        for (int k = 0; k < NV; k++)
        begin
            v[k] = 0;
            for (int a = 0; a < 3; a++)
                v[k] += (r[a][strot_pkg::VOIGT_I[k]] * m[a][strot_pkg::VOIGT_J[k]]) >>> ROT_FR;
            if (v[k] > STRESS_HI)
            begin
                v[k] = STRESS_HI;
                res.saturated = 1'b1;
            end
            else if (v[k] < STRESS_LO)
            begin
                v[k] = STRESS_LO;
                res.saturated = 1'b1;
            end
        end
        res.rotated_xx = v[0][SW-1:0];
        res.rotated_yy = v[1][SW-1:0];
        res.rotated_zz = v[2][SW-1:0];
        res.rotated_xy = v[3][SW-1:0];
        res.rotated_xz = v[4][SW-1:0];
        res.rotated_yz = v[5][SW-1:0];
        return res;
    endfunction

    function automatic logic [3*ROT_W-1:0] pack_row(logic [ROT_W-1:0] c0, logic [ROT_W-1:0] c1,
                                                    logic [ROT_W-1:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic strot_pkg::stress_in_t all_same(logic [SW-1:0] c0, logic [SW-1:0] c1,
                                                       logic [SW-1:0] c2, logic [SW-1:0] c3,
                                                       logic [SW-1:0] c4, logic [SW-1:0] c5);
        strot_pkg::stress_in_t col;
        col.stress_xx = c0;
        col.stress_yy = c1;
        col.stress_zz = c2;
        col.stress_xy = c3;
        col.stress_xz = c4;
        col.stress_yz = c5;
        return col;
    endfunction

    function automatic logic [ROT_W-1:0] random_entry(bit full_range);
        if (full_range)
            return ROT_W'($urandom);
        return ROT_W'($urandom_range(0, 2 * ROT_ONE) - ROT_ONE);
    endfunction

    function automatic logic [3*ROT_W-1:0] random_row(bit full_range);
        return pack_row(random_entry(full_range), random_entry(full_range),
                        random_entry(full_range));
    endfunction

    function automatic logic [SW-1:0] random_component();
        logic signed [SW-1:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0, 1: return raw;
            2, 3: return raw >>> $urandom_range(4, 28);
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return S_ZERO;
                    default: return S_NEG1;
                endcase
            end
            default: return raw >>> 12;
        endcase
    endfunction

    function automatic strot_pkg::stress_in_t random_column();
        strot_pkg::stress_in_t col;
        col.stress_xx = random_component();
        col.stress_yy = random_component();
        col.stress_zz = random_component();
        col.stress_xy = random_component();
        col.stress_xz = random_component();
        col.stress_yz = random_component();
        return col;
    endfunction

    task automatic write_rotation(strot_pkg::cfg_index_t idx, logic [3*ROT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= strot_pkg::CFG_ROT_ROW2)
            rot_rows[idx] = value;
    endtask

    task automatic set_rotation(logic [3*ROT_W-1:0] row0, logic [3*ROT_W-1:0] row1,
                                logic [3*ROT_W-1:0] row2);
        write_rotation(strot_pkg::CFG_ROT_ROW0, row0);
        write_rotation(strot_pkg::CFG_ROT_ROW1, row1);
        write_rotation(strot_pkg::CFG_ROT_ROW2, row2);
        @(negedge clk);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_columns.size() != 0 || expected_tensors.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_columns(int count);
        @(negedge clk);
        repeat (count) pending_columns.push_back(random_column());
        drain();
    endtask

    task automatic compare_field(string field, logic [SW-1:0] want, logic [SW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            stress <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                expected_tensors.push_back(rotate_tensor(stress));
                void'(pending_columns.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_columns.size() != 0)
            begin
                start <= 1'b1;
                stress <= pending_columns[0];
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_tensors.size() == 0)
            begin
                $display("%0t: result expected none actual %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                oldest_tensor = expected_tensors.pop_front();
                compare_field("rotated_xx", oldest_tensor.rotated_xx, result.rotated_xx);
                compare_field("rotated_yy", oldest_tensor.rotated_yy, result.rotated_yy);
                compare_field("rotated_zz", oldest_tensor.rotated_zz, result.rotated_zz);
                compare_field("rotated_xy", oldest_tensor.rotated_xy, result.rotated_xy);
                compare_field("rotated_xz", oldest_tensor.rotated_xz, result.rotated_xz);
                compare_field("rotated_yz", oldest_tensor.rotated_yz, result.rotated_yz);
                compare_field("saturated", SW'(oldest_tensor.saturated), SW'(result.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        for (int k = 0; k < 3; k++)
            rot_rows[k] = (3*ROT_W)'(ROT_ONE) << (ROT_W * k);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Identity rotation straight out of reset: results must equal the inputs.
        @(negedge clk);
        pending_columns.push_back(all_same(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO));
        pending_columns.push_back(all_same(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        pending_columns.push_back(all_same(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        pending_columns.push_back(all_same(S_NEG1, S_NEG1, S_NEG1, S_NEG1, S_NEG1, S_NEG1));
        pending_columns.push_back(all_same(S_UNIT, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO));
        pending_columns.push_back(all_same(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
        pending_columns.push_back(all_same(S_ZERO, S_ZERO, S_ZERO, S_UNIT, S_NEG1, S_MAX));
        pending_columns.push_back(all_same(S_ALT5, S_ALTA, S_ALT5, S_ALTA, S_ALT5, S_ALTA));
        drain();
        random_columns(90);

        // Quarter turn about z, plus a write to an index past the register list.
        set_rotation(pack_row(ROT_ZERO, ROT_NEG_ONE, ROT_ZERO),
                     pack_row(ROT_ONE, ROT_ZERO, ROT_ZERO),
                     pack_row(ROT_ZERO, ROT_ZERO, ROT_ONE));
        write_rotation(CFG_UNUSED, random_row(1'b1));
        random_columns(90);

        // Largest positive entries drive the sums out of range.
        set_rotation(pack_row(ROT_MAX, ROT_MAX, ROT_MAX), pack_row(ROT_MAX, ROT_MAX, ROT_MAX),
                     pack_row(ROT_MAX, ROT_MAX, ROT_MAX));
        pending_columns.push_back(all_same(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        pending_columns.push_back(all_same(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        pending_columns.push_back(all_same(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO));
        pending_columns.push_back(all_same(S_UNIT, S_UNIT, S_UNIT, S_UNIT, S_UNIT, S_UNIT));
        drain();
        random_columns(90);

        set_rotation(pack_row(ROT_MIN, ROT_MIN, ROT_MIN), pack_row(ROT_MIN, ROT_MIN, ROT_MIN),
                     pack_row(ROT_MIN, ROT_MIN, ROT_MIN));
        pending_columns.push_back(all_same(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX));
        pending_columns.push_back(all_same(S_NEG1, S_NEG1, S_NEG1, S_NEG1, S_NEG1, S_NEG1));
        drain();
        random_columns(90);

        set_rotation(pack_row(ROT_ZERO, ROT_ZERO, ROT_ZERO), pack_row(ROT_ZERO, ROT_ZERO, ROT_ZERO),
                     pack_row(ROT_ZERO, ROT_ZERO, ROT_ZERO));
        random_columns(60);

        set_rotation(random_row(1'b1), random_row(1'b1), random_row(1'b1));
        random_columns(95);

        set_rotation(random_row(1'b0), random_row(1'b0), random_row(1'b0));
        random_columns(95);

        // Axis permutation with sign flips.
        set_rotation(pack_row(ROT_ZERO, ROT_ZERO, ROT_NEG_ONE),
                     pack_row(ROT_NEG_ONE, ROT_ZERO, ROT_ZERO),
                     pack_row(ROT_ZERO, ROT_ONE, ROT_ZERO));
        random_columns(90);

        set_rotation(random_row(1'b0), random_row(1'b0), random_row(1'b0));
        random_columns(95);

        set_rotation(random_row(1'b1), random_row(1'b1), random_row(1'b1));
        write_rotation(CFG_UNUSED, random_row(1'b1));
        random_columns(95);

        set_rotation(pack_row(ROT_ONE, ROT_ZERO, ROT_ZERO), pack_row(ROT_ZERO, ROT_ONE, ROT_ZERO),
                     pack_row(ROT_ZERO, ROT_ZERO, ROT_ONE));
        random_columns(50);

        repeat (12) @(negedge clk);
        if (mismatch_count == 0 && expected_tensors.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
